### hw/rtl/uniform_grid_cubic_interpolator_assert.svh
// Assertion macros shared by the interpolator RTL.
`ifndef UNIFORM_GRID_CUBIC_INTERPOLATOR_ASSERT_SVH
`define UNIFORM_GRID_CUBIC_INTERPOLATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// when ante holds at an edge, cons holds at the same edge
`define UGCI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ugci implication check failed");
// expr never holds at any edge out of reset
`define UGCI_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("ugci forbidden condition seen");
`else
`define UGCI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UGCI_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### hw/rtl/ugci_pkg.sv
// Shared constants, types and helpers of the cubic grid interpolator.
package ugci_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int TAB_AW      = $clog2(TABLE_DEPTH);
	localparam int BANKS       = 4;
	localparam int BANK_ROWS   = TABLE_DEPTH / BANKS;
	localparam int BANK_AW     = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;

	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int POS_W = 32;
	localparam int RES_W = 31;
	localparam int LE_W  = 10;

	localparam int TFRAC = 40;
	localparam int XFRAC = 22;
	localparam int X_W   = 25;
	localparam int H_W   = 40;
	localparam int P_W   = H_W + X_W;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);
	localparam int OCC_W   = Q_CW + 1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic [1:0] CFG_ORIGIN   = 2'd0;
	localparam logic [1:0] CFG_INV_STEP = 2'd1;
	localparam logic [1:0] CFG_LAST     = 2'd2;

	localparam logic [POS_W-1:0] ORIGIN_RST   = 32'h0000_0000;
	localparam logic [31:0]      INV_STEP_RST = 32'h0001_0000;
	localparam logic [LE_W-1:0]  LAST_RST     = 10'd1023;

	// ceil(2^34 / 3): exact floor(n / 3) for any 33-bit n after >> 34
	localparam logic [32:0] DIV3_MAGIC = 33'h1_5555_5556;

	typedef struct packed {
		logic                    is_write;
		logic                    oor;
		logic [IDX_W-1:0]        idx;
		logic [VAL_W-1:0]        value;
		logic signed [X_W-1:0]   x;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t item;
	} q_push_t;

	typedef struct packed {
		logic [Q_CW-1:0] level;
		logic            not_empty;
	} q_status_t;

	function automatic logic [TAB_AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
		logic [31:0] w;
		w = 32'(idx);
		return w[TAB_AW-1:0];
	endfunction

	function automatic logic [BANK_AW-1:0] bank_row(input logic [TAB_AW-1:0] a);
		logic [31:0] w;
		w = 32'(a) >> 2;
		return w[BANK_AW-1:0];
	endfunction

endpackage

### hw/rtl/ugci_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ugci_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/ugci_front.sv
// Front end: takes items, maps a position onto the grid and classifies it.
`include "uniform_grid_cubic_interpolator_assert.svh"

module ugci_front
	import ugci_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    operation,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic signed [VAL_W-1:0] entry_value,
	input  logic signed [POS_W-1:0] position,
	input  logic signed [POS_W-1:0] grid_origin,
	input  logic [31:0]             grid_inverse_step,
	input  logic [LE_W-1:0]         last_entry,
	input  q_status_t               q_status,
	output q_push_t                 push
);

	logic                   v_s1, v_s2;
	logic                   op_s1, op_s2;
	logic [IDX_W-1:0]       idx_s1, idx_s2;
	logic [VAL_W-1:0]       value_s1, value_s2;
	logic signed [POS_W:0]  diff_s1;
	logic                   neg_s2;
	logic [63:0]            t_s2;

	logic                   accept;
	logic [OCC_W-1:0]       occ;
	logic [LE_W-1:0]        le_eff, le_m2, tint, base, dd;
	logic                   oor;

	// every item in flight here already owns a queue slot
	assign occ = OCC_W'(q_status.level) + OCC_W'(v_s1) + OCC_W'(v_s2);
	assign in_stall = (occ >= OCC_W'(Q_DEPTH));
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= operation;
		idx_s1   <= entry_index;
		value_s1 <= entry_value;
		diff_s1  <= {position[POS_W-1], position} - {grid_origin[POS_W-1], grid_origin};
		op_s2    <= op_s1;
		idx_s2   <= idx_s1;
		value_s2 <= value_s1;
		neg_s2   <= diff_s1[POS_W];
		t_s2     <= diff_s1[POS_W-1:0] * grid_inverse_step;
	end

	// t is Q24.40; past last_entry or below the origin the query only flags
	assign le_eff = (last_entry < LE_W'(3)) ? LE_W'(3) : last_entry;
	assign le_m2  = le_eff - LE_W'(2);
	assign tint   = t_s2[TFRAC+LE_W-1:TFRAC];
	assign oor    = neg_s2 || (t_s2[63:TFRAC+LE_W] != '0) ||
	                (t_s2[TFRAC+LE_W-1:0] > {le_eff, {TFRAC{1'b0}}});

	always_comb begin
		if (tint == '0) begin
			base = LE_W'(1);
		end else if (tint > le_m2) begin
			base = le_m2;
		end else begin
			base = tint;
		end
	end

	// integer part of x is floor(t) - base, from -1 to 2
	assign dd = tint - base;

	always_comb begin
		push.valid         = v_s2;
		push.item.is_write = (op_s2 == OP_WRITE);
		push.item.oor      = oor;
		push.item.idx      = (op_s2 == OP_WRITE) ? idx_s2 : base;
		push.item.value    = value_s2;
		push.item.x        = {dd[2:0], t_s2[TFRAC-1:TFRAC-XFRAC]};
	end

	`UGCI_ASSERT_NEVER(a_front_credit, clk, arst_n, occ > OCC_W'(Q_DEPTH))

endmodule

### hw/rtl/ugci_queue.sv
// Short queue of classified words between front and back end.
`include "uniform_grid_cubic_interpolator_assert.svh"

module ugci_queue
	import ugci_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  q_push_t   push,
	input  logic      pop,
	output q_status_t status,
	output work_t     head
);

	work_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0] level_q;

	function automatic logic [Q_AW-1:0] ptr_next(input logic [Q_AW-1:0] p);
		return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push.valid, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	assign head             = mem_q[rd_ptr_q];
	assign status.level     = level_q;
	assign status.not_empty = (level_q != '0);

	`UGCI_ASSERT_NEVER(a_q_overflow, clk, arst_n, push.valid && !pop && (level_q == Q_CW'(Q_DEPTH)))
	`UGCI_ASSERT_NEVER(a_q_underflow, clk, arst_n, pop && (level_q == '0))

endmodule

### hw/rtl/ugci_back.sv
// Back end: banked sample table, Lagrange weights, Horner pipeline, output word.
`include "uniform_grid_cubic_interpolator_assert.svh"

module ugci_back
	import ugci_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  work_t            head,
	input  q_status_t        q_status,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [RES_W-1:0] result_value,
	output logic             out_of_range
);

	localparam logic signed [H_W-1:0] SAT_LIMIT = 40'sd12884901888;

	logic                    adv, wr, rd;
	logic [TAB_AW-1:0]       wa, a0;
	logic [VAL_W-1:0]        rdata [BANKS];

	logic                    v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic                    oor_s2, oor_s3, oor_s4, oor_s5, oor_s6, oor_s7, oor_s8;
	logic [1:0]              rot_s2;
	logic signed [X_W-1:0]   x_s2, x_s3, x_s4, x_s5;
	logic signed [H_W-1:0]   k0_s3, k1_s3, k2_s3, k3_s3;
	logic signed [H_W-1:0]   k0_s4, k1_s4, k2_s4, k0_s5, k1_s5, k0_s6;
	logic signed [P_W-1:0]   m1_s4, m2_s5, m3_s6;
	logic signed [H_W-1:0]   h_s7;
	logic                    pos_s8, sat_s8;
	logic [49:0]             pa_s8;
	logic [48:0]             pb_s8;

	logic                    out_valid_q, oor_q;
	logic [RES_W-1:0]        result_q;

	logic signed [H_W-1:0]   sv [BANKS];
	logic signed [H_W-1:0]   k0, k1, k2, k3, h1, h2;
	logic [32:0]             n;
	logic [65:0]             qsum;

	// whole back end moves as one while the output word is free or taken
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && q_status.not_empty;
	assign wr  = pop && head.is_write;
	assign rd  = pop && !head.is_write;
	assign wa  = to_addr(head.idx);
	assign a0  = to_addr(head.idx) - 1'b1;

	// four neighbors are consecutive entries, so each lands in its own bank
	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic [1:0]        off;
		logic [TAB_AW-1:0] ent;
		logic              we;

		assign off = 2'(b) - a0[1:0];
		assign ent = a0 + TAB_AW'(off);
		assign we  = wr && (wa[1:0] == 2'(b));

		ugci_ram #(
			.WIDTH(VAL_W),
			.DEPTH(BANK_ROWS)
		) u_ram (
			.clk     (clk),
			.wr_en   (we),
			.wr_addr (bank_row(wa)),
			.wr_data (head.value),
			.rd_en   (rd),
			.rd_addr (bank_row(ent)),
			.rd_data (rdata[b])
		);
	end

	always_comb begin
		logic [VAL_W-1:0] r;
		r = '0;
		for (int j = 0; j < BANKS; j++) begin
			r = rdata[2'(rot_s2 + 2'(j))];
			sv[j] = {{(H_W-VAL_W){r[VAL_W-1]}}, r};
		end
	end

	// six times the Lagrange coefficients, all integer
	assign k0 = (sv[1] <<< 2) + (sv[1] <<< 1);
	assign k1 = -(sv[0] <<< 1) - ((sv[1] <<< 1) + sv[1]) + ((sv[2] <<< 2) + (sv[2] <<< 1))
	            - sv[3];
	assign k2 = ((sv[0] <<< 1) + sv[0]) - ((sv[1] <<< 2) + (sv[1] <<< 1))
	            + ((sv[2] <<< 1) + sv[2]);
	assign k3 = -sv[0] + ((sv[1] <<< 1) + sv[1]) - ((sv[2] <<< 1) + sv[2]) + sv[3];

	// floor each product back to the sample scale
	assign h1 = H_W'(m1_s4 >>> XFRAC) + k2_s4;
	assign h2 = H_W'(m2_s5 >>> XFRAC) + k1_s5;

	// positive and unsaturated h stays below 6 * 2^31, so h / 6 = (h >> 1) / 3
	assign n    = h_s7[33:1];
	assign qsum = {pa_s8, 16'b0} + 66'(pb_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s2        <= rd;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			out_valid_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s2 <= head.oor;
			x_s2   <= head.x;
			rot_s2 <= a0[1:0];

			oor_s3 <= oor_s2;
			x_s3   <= x_s2;
			k0_s3  <= k0;
			k1_s3  <= k1;
			k2_s3  <= k2;
			k3_s3  <= k3;

			oor_s4 <= oor_s3;
			x_s4   <= x_s3;
			k0_s4  <= k0_s3;
			k1_s4  <= k1_s3;
			k2_s4  <= k2_s3;
			m1_s4  <= k3_s3 * x_s3;

			oor_s5 <= oor_s4;
			x_s5   <= x_s4;
			k0_s5  <= k0_s4;
			k1_s5  <= k1_s4;
			m2_s5  <= h1 * x_s4;

			oor_s6 <= oor_s5;
			k0_s6  <= k0_s5;
			m3_s6  <= h2 * x_s5;

			oor_s7 <= oor_s6;
			h_s7   <= H_W'(m3_s6 >>> XFRAC) + k0_s6;

			oor_s8 <= oor_s7;
			pos_s8 <= !h_s7[H_W-1] && (h_s7 != '0);
			sat_s8 <= (h_s7 >= SAT_LIMIT);
			pa_s8  <= n[32:16] * DIV3_MAGIC;
			pb_s8  <= n[15:0] * DIV3_MAGIC;

			oor_q  <= oor_s8;
			if (oor_s8 || !pos_s8) begin
				result_q <= '0;
			end else if (sat_s8) begin
				result_q <= '1;
			end else begin
				result_q <= qsum[64:34];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign out_of_range = oor_q;

	`UGCI_ASSERT_IMP(a_oor_zero, clk, arst_n, out_valid_q && oor_q, result_q == '0)

endmodule

### hw/rtl/uniform_grid_cubic_interpolator.sv
// A query result shows on out_valid after the front stages, queue and back end.
// Throughput: one item per cycle when not stalled; the back end has one table read
// per cycle over four banked RAMs, so writes and queries each take one slot.
// in_stall rises once queued words plus words in the two front stages reach 4.
// Reset (arst_n low) clears all valid state and loads origin 0, step 1.0, last 1023;
// the sample table is not cleared and holds garbage until written.
module uniform_grid_cubic_interpolator
	import ugci_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    operation,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic signed [VAL_W-1:0] entry_value,
	input  logic signed [POS_W-1:0] position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [RES_W-1:0]        result_value,
	output logic                    out_of_range,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [31:0]             cfg_data
);

	logic signed [POS_W-1:0] origin_q;
	logic [31:0]             inv_step_q;
	logic [LE_W-1:0]         last_q;

	q_push_t   push;
	q_status_t q_status;
	work_t     head;
	logic      pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q   <= ORIGIN_RST;
			inv_step_q <= INV_STEP_RST;
			last_q     <= LAST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORIGIN:   origin_q   <= cfg_data;
				CFG_INV_STEP: inv_step_q <= cfg_data;
				CFG_LAST:     last_q     <= cfg_data[LE_W-1:0];
				default: begin
					// drop writes past the register list
				end
			endcase
		end
	end

	ugci_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.operation         (operation),
		.entry_index       (entry_index),
		.entry_value       (entry_value),
		.position          (position),
		.grid_origin       (origin_q),
		.grid_inverse_step (inv_step_q),
		.last_entry        (last_q),
		.q_status          (q_status),
		.push              (push)
	);

	ugci_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.status (q_status),
		.head   (head)
	);

	ugci_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.out_of_range (out_of_range)
	);

endmodule
